// ===== hdl/pwr_pkg.sv =====
// Package for the particle weighted resampler.
// Holds sizes, the memory word layout and the sequencer states.
// No dependencies.
package pwr_pkg;

  localparam int PARTICLE_COUNT = 64;
  localparam int IDX_W          = $clog2(PARTICLE_COUNT);
  localparam int CNT_W          = $clog2(PARTICLE_COUNT + 1);

  localparam int COORD_W  = 16;
  localparam int WEIGHT_W = 32;
  localparam int DRAW_W   = 16;
  localparam int TOTAL_W  = 38;
  localparam int SUM_W    = 22;
  localparam int PROD_W   = DRAW_W + TOTAL_W;

  localparam int IN_W  = 96;
  localparam int OUT_W = 104;

  typedef struct packed {
    logic [COORD_W-1:0] heading;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } pose_t;

  typedef struct packed {
    logic [DRAW_W-1:0]  draw;
    logic [TOTAL_W-1:0] cum;
    pose_t              pose;
  } mem_word_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_DRAW,
    S_MUL,
    S_PROBE,
    S_CMP,
    S_POSE,
    S_OUT
  } state_e;

endpackage

// ===== hdl/particle_weighted_resampler.sv =====
// Top level of the particle weighted resampler: loader, binary search and emitter.
// Depends on pwr_pkg.
//
// Loads PARTICLE_COUNT particles at one transaction per clock, storing each pose, its
// cumulative weight and its draw in a single synchronous memory. After the last load no
// input is taken while one resampled particle is emitted per stored draw, in load order.
// Each result is built in order: one memory read for the draw, one multiply, a binary
// search over the cumulative weights with one memory read and compare per step, and one
// read for the chosen pose; the single memory read port keeps these steps sequential.
// With a zero total weight the search is skipped. The last result carries the mean pose
// and tlast.
module particle_weighted_resampler (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // x[15:0], y[31:16], heading[47:32], weight[79:48], draw[95:80]
  input  logic [pwr_pkg::IN_W-1:0] s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // out_x[15:0], out_y[31:16], out_heading[47:32], source_index[53:48],
  // mean_x[69:54], mean_y[85:70], mean_heading[101:86], zero[103:102]
  output logic [pwr_pkg::OUT_W-1:0] m_axis_tdata,
  output logic                      m_axis_tlast
);
  import pwr_pkg::*;

  localparam logic signed [SUM_W-1:0] N_S = SUM_W'(PARTICLE_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PARTICLE_COUNT - 1);

  state_e state_q, state_d;

  logic [CNT_W-1:0]   load_cnt_q, load_cnt_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [IDX_W-1:0]   emit_q, emit_d;
  logic [IDX_W-1:0]   lo_q, lo_d, hi_q, hi_d;
  logic [PROD_W-1:0]  lhs_q, lhs_d;
  logic signed [SUM_W-1:0] sum_x_q, sum_x_d, sum_y_q, sum_y_d, sum_h_q, sum_h_d;

  logic               out_valid_q, out_valid_d;
  logic [OUT_W-1:0]   out_data_q, out_data_d;
  logic               out_last_q, out_last_d;

  mem_word_t          mem [PARTICLE_COUNT];
  mem_word_t          rd_q;
  mem_word_t          wr_word;
  logic               wr_en, rd_en;
  logic [IDX_W-1:0]   wr_addr, rd_addr;

  logic               in_fire, out_free, is_last;
  logic [IDX_W:0]     mid_sum;
  logic [IDX_W-1:0]   mid;
  pose_t              in_pose;
  logic [WEIGHT_W-1:0] in_weight;
  logic [DRAW_W-1:0]  in_draw;
  logic [TOTAL_W-1:0] total_inc;
  logic signed [SUM_W-1:0] nsum_x, nsum_y, nsum_h, q_x, q_y, q_h;
  logic [COORD_W-1:0] mean_x, mean_y, mean_h;

  assign s_axis_tready = (state_q == S_LOAD);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign is_last       = (emit_q == LAST_IDX);

  assign in_pose   = pose_t'(s_axis_tdata[3*COORD_W-1:0]);
  assign in_weight = s_axis_tdata[3*COORD_W +: WEIGHT_W];
  assign in_draw   = s_axis_tdata[3*COORD_W+WEIGHT_W +: DRAW_W];
  assign total_inc = total_q + TOTAL_W'(in_weight);

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[IDX_W:1];

  assign nsum_x = sum_x_q + {{(SUM_W-COORD_W){rd_q.pose.x[COORD_W-1]}}, rd_q.pose.x};
  assign nsum_y = sum_y_q + {{(SUM_W-COORD_W){rd_q.pose.y[COORD_W-1]}}, rd_q.pose.y};
  assign nsum_h = sum_h_q +
                  {{(SUM_W-COORD_W){rd_q.pose.heading[COORD_W-1]}}, rd_q.pose.heading};
  assign q_x    = nsum_x / N_S;
  assign q_y    = nsum_y / N_S;
  assign q_h    = nsum_h / N_S;
  assign mean_x = is_last ? q_x[COORD_W-1:0] : '0;
  assign mean_y = is_last ? q_y[COORD_W-1:0] : '0;
  assign mean_h = is_last ? q_h[COORD_W-1:0] : '0;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_LOAD: begin
        if (in_fire && load_cnt_q == CNT_W'(PARTICLE_COUNT - 1)) state_d = S_DRAW;
      end
      S_DRAW:  state_d = S_MUL;
      S_MUL:   state_d = S_PROBE;
      S_PROBE: state_d = (lo_q == hi_q) ? S_POSE : S_CMP;
      S_CMP:   state_d = S_PROBE;
      S_POSE:  state_d = S_OUT;
      S_OUT: begin
        if (out_free) state_d = is_last ? S_LOAD : S_DRAW;
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_comb begin
    load_cnt_d  = load_cnt_q;
    total_d     = total_q;
    emit_d      = emit_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    lhs_d       = lhs_q;
    sum_x_d     = sum_x_q;
    sum_y_d     = sum_y_q;
    sum_h_d     = sum_h_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_valid_d = m_axis_tready ? 1'b0 : out_valid_q;
    wr_en       = 1'b0;
    wr_addr     = load_cnt_q[IDX_W-1:0];
    wr_word     = '{draw: in_draw, cum: total_inc, pose: in_pose};
    rd_en       = 1'b0;
    rd_addr     = emit_q;
    unique case (state_q)
      S_LOAD: begin
        if (in_fire) begin
          wr_en   = 1'b1;
          total_d = total_inc;
          if (load_cnt_q == CNT_W'(PARTICLE_COUNT - 1)) begin
            load_cnt_d = '0;
            emit_d     = '0;
          end else begin
            load_cnt_d = load_cnt_q + CNT_W'(1);
          end
        end
      end
      S_DRAW: begin
        rd_en   = 1'b1;
        rd_addr = emit_q;
      end
      S_MUL: begin
        lhs_d = PROD_W'(rd_q.draw) * PROD_W'(total_q);
        if (total_q == '0) begin
          lo_d = LAST_IDX;
          hi_d = LAST_IDX;
        end else begin
          lo_d = '0;
          hi_d = LAST_IDX;
        end
      end
      S_PROBE: begin
        rd_en   = 1'b1;
        rd_addr = (lo_q == hi_q) ? lo_q : mid;
      end
      S_CMP: begin
        if (lhs_q <= {rd_q.cum, {DRAW_W{1'b0}}}) begin
          hi_d = mid;
        end else begin
          lo_d = mid + IDX_W'(1);
        end
      end
      S_POSE: begin
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d  = is_last;
          out_data_d  = {{(OUT_W-6*COORD_W-IDX_W){1'b0}}, mean_h, mean_y, mean_x,
                         lo_q, rd_q.pose.heading, rd_q.pose.y, rd_q.pose.x};
          emit_d      = emit_q + IDX_W'(1);
          if (is_last) begin
            sum_x_d = '0;
            sum_y_d = '0;
            sum_h_d = '0;
            total_d = '0;
          end else begin
            sum_x_d = nsum_x;
            sum_y_d = nsum_y;
            sum_h_d = nsum_h;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_word;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      load_cnt_q  <= '0;
      total_q     <= '0;
      emit_q      <= '0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      sum_h_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      load_cnt_q  <= load_cnt_d;
      total_q     <= total_d;
      emit_q      <= emit_d;
      sum_x_q     <= sum_x_d;
      sum_y_q     <= sum_y_d;
      sum_h_q     <= sum_h_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    lhs_q      <= lhs_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule
